// ----- design/nfa_pkg.sv -----
// Shared types and constants for the neighbour force accumulator.
// Used by nfa_alu, nfa_regs and the top level; no dependencies.
`timescale 1ns / 1ps
package nfa_pkg;

  localparam int POS_FRAC = 8;
  localparam logic [7:0] MAX_NBR = 8'd255;
  localparam logic [63:0] ONE_Q16 = 64'd65536;
  localparam logic [63:0] TERM_CAP = 64'd1 << 36;
  localparam logic [63:0] TERM_NUM = 64'd1000 << (16 + 2 * POS_FRAC);
  localparam logic [63:0] NEAR_MAG = 64'd1000 << POS_FRAC;
  localparam logic [25:0] NEAR_LIMIT = 26'(300 << POS_FRAC);

  localparam logic [2:0] CFG_RANGE = 3'd0;
  localparam logic [2:0] CFG_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_ZCROSS = 3'd2;
  localparam logic [2:0] CFG_AGE_EN = 3'd3;
  localparam logic [2:0] CFG_DIST_EN = 3'd4;
  localparam logic [2:0] CFG_AVG_EN = 3'd5;
  localparam logic [2:0] CFG_WAVG = 3'd6;

  typedef struct packed {
    logic        command;
    logic [23:0] neighbour_x;
    logic [23:0] neighbour_y;
    logic [23:0] own_x;
    logic [23:0] own_y;
    logic        contact_expired;
    logic [23:0] ping_age;
  } in_word_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [7:0]  target_count;
    logic [23:0] weight_total;
    logic        force_valid;
    logic        divide_fault;
  } out_word_t;

  typedef struct packed {
    logic [23:0] range_limit;
    logic [23:0] age_timeout;
    logic [23:0] zero_cross_distance;
    logic        use_age_weight;
    logic        use_distance_weight;
    logic        average_enable;
    logic        weighted_average;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_RANGE,
    S_NMX,
    S_NDX,
    S_NMY,
    S_NDY,
    S_E2,
    S_TERM,
    S_KX,
    S_KY,
    S_WA,
    S_WD,
    S_W,
    S_FX,
    S_FY,
    S_ACC,
    S_AX,
    S_AY,
    S_OUT
  } state_t;

endpackage

// ----- design/nfa_alu.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, integer square root.
// One bit (or one root digit) per cycle on a single 65-bit adder. Uses nfa_pkg.
`timescale 1ns / 1ps
module nfa_alu import nfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r, done_r;
  alu_op_t     op_r;
  logic [63:0] x_r, y_r, z_r;
  logic [5:0]  cnt_r;

  logic [64:0] rem2;
  logic [63:0] p, q;
  logic        sub;
  logic [64:0] s;
  logic        ge;

  always_comb begin
    rem2 = {x_r, z_r[63]};
    p    = x_r;
    q    = y_r;
    sub  = 1'b0;
    case (op_r)
      ALU_MUL:  begin p = x_r; q = y_r; sub = 1'b0; end
      ALU_DIV:  begin p = rem2[63:0]; q = y_r; sub = 1'b1; end
      ALU_SQRT: begin p = x_r; q = y_r | z_r; sub = 1'b1; end
      default:  begin p = x_r; q = y_r; sub = 1'b0; end
    endcase
    s  = {1'b0, p} + {1'b0, (sub ? ~q : q)} + {64'd0, sub};
    ge = s[64] | ((op_r == ALU_DIV) & rem2[64]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        case (req.op)
          ALU_MUL:  begin x_r <= '0; y_r <= req.a; z_r <= req.b; cnt_r <= 6'd63; end
          ALU_DIV:  begin x_r <= '0; y_r <= req.b; z_r <= req.a; cnt_r <= 6'd63; end
          ALU_SQRT: begin x_r <= req.a; y_r <= '0; z_r <= 64'd1 << 62; cnt_r <= 6'd31; end
          default:  begin x_r <= '0; y_r <= '0; z_r <= '0; cnt_r <= '0; end
        endcase
      end else if (busy_r) begin
        case (op_r)
          ALU_MUL: begin
            if (z_r[0]) x_r <= s[63:0];
            y_r <= y_r << 1;
            z_r <= z_r >> 1;
          end
          ALU_DIV: begin
            x_r <= ge ? s[63:0] : rem2[63:0];
            z_r <= {z_r[62:0], ge};
          end
          ALU_SQRT: begin
            if (ge) begin
              x_r <= s[63:0];
              y_r <= (y_r >> 1) | z_r;
            end else begin
              y_r <= y_r >> 1;
            end
            z_r <= z_r >> 2;
          end
          default: ;
        endcase
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    case (op_r)
      ALU_MUL:  rsp.result = x_r;
      ALU_DIV:  rsp.result = z_r;
      ALU_SQRT: rsp.result = y_r;
      default:  rsp.result = x_r;
    endcase
  end

endmodule

// ----- design/nfa_regs.sv -----
// Configuration register file for the neighbour force accumulator.
// Plain write port, no read-back. Uses nfa_pkg.
`timescale 1ns / 1ps
module nfa_regs import nfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_limit         <= 24'd166400;
      cfg_r.age_timeout         <= 24'd2560;
      cfg_r.zero_cross_distance <= 24'd0;
      cfg_r.use_age_weight      <= 1'b1;
      cfg_r.use_distance_weight <= 1'b1;
      cfg_r.average_enable      <= 1'b0;
      cfg_r.weighted_average    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGE:   cfg_r.range_limit         <= cfg_wdata;
        CFG_TIMEOUT: cfg_r.age_timeout         <= cfg_wdata;
        CFG_ZCROSS:  cfg_r.zero_cross_distance <= cfg_wdata;
        CFG_AGE_EN:  cfg_r.use_age_weight      <= cfg_wdata[0];
        CFG_DIST_EN: cfg_r.use_distance_weight <= cfg_wdata[0];
        CFG_AVG_EN:  cfg_r.average_enable      <= cfg_wdata[0];
        CFG_WAVG:    cfg_r.weighted_average    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/neighbour_force_accumulator.sv -----
// Neighbour force accumulator: a skipped report ends in idle, one out of range leaves
// after the range check, a full report runs the force chain; a finish divides both
// sums first when averaging, then waits in the output state through any output stall.
// The time goes to the shared multiply/divide/root unit. One word is in work at a time;
// the result register lets the next word enter while a result waits. Synchronous
// active-low reset restores the register defaults and clears sums; no clearing pass.
`timescale 1ns / 1ps
module neighbour_force_accumulator import nfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  cfg_t      cfg;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;

  state_t    state_r, state_nxt;
  logic      issued_r;
  logic      need_op, adv, in_acc, out_load;

  logic [23:0] rxm_r, rym_r, age_r;
  logic        rxs_r, rys_r;
  logic [63:0] t_r;
  logic [25:0] d_r;
  logic [24:0] em_r;
  logic [36:0] km_r;
  logic        ks_r;
  logic [45:0] fxm_r, fym_r;
  logic        fxs_r, fys_r;
  logic [16:0] wa_r, wd_r, w_r;
  logic signed [47:0] sfx_r, sfy_r;
  logic [23:0] sw_r;
  logic [7:0]  cnt_r;
  logic [63:0] oxm_r, oym_r;
  logic        oxs_r, oys_r, fault_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic signed [24:0] rx, ry;
  logic signed [26:0] e;
  logic [63:0] term;
  logic        age_zero, rng_zero;
  logic signed [48:0] fx49, fy49, nx49, ny49;
  logic [24:0] sw25;

  nfa_regs u_regs (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cfg(cfg)
  );

  nfa_alu u_alu (.clk(clk), .rst_n(rst_n), .req(alu_req), .rsp(alu_rsp));

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rx = 25'(signed'(in_data.neighbour_x)) - 25'(signed'(in_data.own_x));
  assign ry = 25'(signed'(in_data.neighbour_y)) - 25'(signed'(in_data.own_y));
  assign e  = signed'({1'b0, d_r}) - signed'({3'b0, cfg.zero_cross_distance});

  assign age_zero = (cfg.age_timeout == '0) || (age_r >= cfg.age_timeout);
  assign rng_zero = (cfg.range_limit == '0);

  always_comb begin
    if (alu_rsp.result > TERM_CAP) term = TERM_CAP;
    else term = alu_rsp.result;
    if (t_r == '0) term = TERM_CAP;
  end

  // an op state may skip the unit when its value is fixed
  always_comb begin
    unique case (state_r)
      S_SQX, S_SQY, S_SQRT, S_NMX, S_NDX, S_NMY, S_NDY, S_E2, S_KX, S_KY,
      S_W, S_FX, S_FY, S_AX, S_AY: need_op = 1'b1;
      S_TERM: need_op = (t_r != '0);
      S_WA:   need_op = cfg.use_age_weight && !age_zero;
      S_WD:   need_op = cfg.use_distance_weight && !rng_zero;
      default: need_op = 1'b0;
    endcase
    adv = !need_op || alu_rsp.done;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.command) begin
            state_nxt = (cfg.average_enable && sw_r != '0) ? S_AX : S_OUT;
          end else if (in_data.contact_expired || cnt_r >= MAX_NBR) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SQX;
          end
        end
      end
      S_SQX:  if (adv) state_nxt = S_SQY;
      S_SQY:  if (adv) state_nxt = S_SQRT;
      S_SQRT: if (adv) state_nxt = S_RANGE;
      S_RANGE: begin
        if (d_r > {2'b0, cfg.range_limit}) state_nxt = S_IDLE;
        else if (d_r == '0) state_nxt = S_WA;
        else if (d_r < NEAR_LIMIT) state_nxt = S_NMX;
        else state_nxt = S_E2;
      end
      S_NMX:  if (adv) state_nxt = S_NDX;
      S_NDX:  if (adv) state_nxt = S_NMY;
      S_NMY:  if (adv) state_nxt = S_NDY;
      S_NDY:  if (adv) state_nxt = S_WA;
      S_E2:   if (adv) state_nxt = S_TERM;
      S_TERM: if (adv) state_nxt = S_KX;
      S_KX:   if (adv) state_nxt = S_KY;
      S_KY:   if (adv) state_nxt = S_WA;
      S_WA:   if (adv) state_nxt = S_WD;
      S_WD:   if (adv) state_nxt = S_W;
      S_W:    if (adv) state_nxt = S_FX;
      S_FX:   if (adv) state_nxt = S_FY;
      S_FY:   if (adv) state_nxt = S_ACC;
      S_ACC:  state_nxt = S_IDLE;
      S_AX:   if (adv) state_nxt = S_AY;
      S_AY:   if (adv) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit request
  always_comb begin
    alu_req.start = need_op && !issued_r;
    alu_req.op    = ALU_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_r)
      S_SQX: begin alu_req.a = 64'(rxm_r); alu_req.b = 64'(rxm_r); end
      S_SQY: begin alu_req.a = 64'(rym_r); alu_req.b = 64'(rym_r); end
      S_SQRT: begin alu_req.op = ALU_SQRT; alu_req.a = t_r; end
      S_NMX: begin alu_req.a = NEAR_MAG; alu_req.b = 64'(rxm_r); end
      S_NMY: begin alu_req.a = NEAR_MAG; alu_req.b = 64'(rym_r); end
      S_NDX, S_NDY: begin alu_req.op = ALU_DIV; alu_req.a = t_r; alu_req.b = 64'(d_r); end
      S_E2: begin alu_req.a = 64'(em_r); alu_req.b = 64'(em_r); end
      S_TERM: begin alu_req.op = ALU_DIV; alu_req.a = TERM_NUM; alu_req.b = t_r; end
      S_KX: begin alu_req.a = 64'(km_r); alu_req.b = 64'(rxm_r); end
      S_KY: begin alu_req.a = 64'(km_r); alu_req.b = 64'(rym_r); end
      S_WA: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {24'd0, cfg.age_timeout - age_r, 16'd0};
        alu_req.b  = 64'(cfg.age_timeout);
      end
      S_WD: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = {24'd0, cfg.range_limit - d_r[23:0], 16'd0};
        alu_req.b  = 64'(cfg.range_limit);
      end
      S_W:  begin alu_req.a = 64'(wa_r); alu_req.b = 64'(wd_r); end
      S_FX: begin alu_req.a = 64'(fxm_r); alu_req.b = 64'(w_r); end
      S_FY: begin alu_req.a = 64'(fym_r); alu_req.b = 64'(w_r); end
      S_AX, S_AY: begin
        alu_req.op = ALU_DIV;
        alu_req.a  = (state_r == S_AX) ? oxm_r : oym_r;
        alu_req.b  = 64'(sw_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    fx49 = fxs_r ? -signed'({3'b0, fxm_r}) : signed'({3'b0, fxm_r});
    fy49 = fys_r ? -signed'({3'b0, fym_r}) : signed'({3'b0, fym_r});
    nx49 = 49'(sfx_r) + fx49;
    ny49 = 49'(sfy_r) + fy49;
    sw25 = {1'b0, sw_r} + (cfg.weighted_average ? 25'(w_r) : 25'(ONE_Q16));
  end

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (!neg) r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    else r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mag48(input logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? -v : v;
    return 64'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sfx_r       <= '0;
      sfy_r       <= '0;
      sw_r        <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (alu_req.start) issued_r <= 1'b1;
      else if (alu_rsp.done) issued_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (in_acc) begin
          rxs_r <= rx[24];
          rxm_r <= rx[24] ? 24'(-rx) : rx[23:0];
          rys_r <= ry[24];
          rym_r <= ry[24] ? 24'(-ry) : ry[23:0];
          age_r <= in_data.ping_age;
          oxs_r <= sfx_r[47];
          oys_r <= sfy_r[47];
          fault_r <= cfg.average_enable && (sw_r == '0);
          if (!cfg.average_enable) begin
            oxm_r <= mag48(sfx_r);
            oym_r <= mag48(sfy_r);
          end else if (sw_r == '0) begin
            oxm_r <= '0;
            oym_r <= '0;
          end else begin
            oxm_r <= mag48(sfx_r) << 16;
            oym_r <= mag48(sfy_r) << 16;
          end
        end
        S_SQX:  if (adv) t_r <= alu_rsp.result;
        S_SQY:  if (adv) t_r <= t_r + alu_rsp.result;
        S_SQRT: if (adv) d_r <= alu_rsp.result[25:0];
        S_RANGE: begin
          fxm_r <= '0; fym_r <= '0; fxs_r <= 1'b0; fys_r <= 1'b0;
          em_r  <= e[26] ? 25'(-e) : e[24:0];
        end
        S_NMX, S_NMY, S_E2: if (adv) t_r <= alu_rsp.result;
        S_NDX: if (adv) begin fxm_r <= alu_rsp.result[45:0]; fxs_r <= ~rxs_r; end
        S_NDY: if (adv) begin fym_r <= alu_rsp.result[45:0]; fys_r <= ~rys_r; end
        S_TERM: if (adv) begin
          // coefficient k = 1 - term, kept as sign and magnitude
          if (term <= ONE_Q16) begin
            ks_r <= 1'b0; km_r <= 37'(ONE_Q16 - term);
          end else begin
            ks_r <= 1'b1; km_r <= 37'(term - ONE_Q16);
          end
        end
        S_KX: if (adv) begin fxm_r <= alu_rsp.result[61:16]; fxs_r <= ks_r ^ rxs_r; end
        S_KY: if (adv) begin fym_r <= alu_rsp.result[61:16]; fys_r <= ks_r ^ rys_r; end
        S_WA: if (adv) begin
          if (!cfg.use_age_weight) wa_r <= 17'(ONE_Q16);
          else if (age_zero) wa_r <= '0;
          else wa_r <= alu_rsp.result[16:0];
        end
        S_WD: if (adv) begin
          if (!cfg.use_distance_weight) wd_r <= 17'(ONE_Q16);
          else if (rng_zero) wd_r <= '0;
          else wd_r <= alu_rsp.result[16:0];
        end
        S_W:  if (adv) w_r <= alu_rsp.result[32:16];
        S_FX: if (adv) fxm_r <= alu_rsp.result[61:16];
        S_FY: if (adv) fym_r <= alu_rsp.result[61:16];
        S_ACC: begin
          // saturate sums at 48 bits and the weight at 24
          if (nx49[48] != nx49[47]) sfx_r <= nx49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          else sfx_r <= nx49[47:0];
          if (ny49[48] != ny49[47]) sfy_r <= ny49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          else sfy_r <= ny49[47:0];
          sw_r  <= sw25[24] ? 24'hFF_FFFF : sw25[23:0];
          cnt_r <= cnt_r + 8'd1;
        end
        S_AX: if (adv) oxm_r <= alu_rsp.result;
        S_AY: if (adv) oym_r <= alu_rsp.result;
        S_OUT: if (out_load) begin
          out_r.force_x      <= sat32(oxs_r, oxm_r);
          out_r.force_y      <= sat32(oys_r, oym_r);
          out_r.target_count <= cnt_r;
          out_r.weight_total <= sw_r;
          out_r.force_valid  <= (cnt_r != '0);
          out_r.divide_fault <= fault_r;
          sfx_r <= '0;
          sfy_r <= '0;
          sw_r  <= '0;
          cnt_r <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (cnt_r == '0 && sw_r == '0 && sfx_r == '0 && sfy_r == '0))
    else $error("sums not cleared after finish");
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.force_valid == (out_r.target_count != '0)))
    else $error("force_valid disagrees with target_count");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.divide_fault) |-> (out_r.force_x == '0 && out_r.force_y == '0))
    else $error("divide fault with nonzero force");
  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> issued_r)
    else $error("unit finished without a request");
`endif

endmodule

// ----- verif/nfa_checker.sv -----
// Checker for the neighbour force accumulator: watches the word and config ports,
// predicts each finish result and compares it. Depends on nfa_pkg.
`timescale 1ns / 1ps
module nfa_checker import nfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);

  localparam longint SUM_MAX = (64'sd1 <<< 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 47);

  cfg_t      regs;
  longint    acc_x, acc_y;
  int unsigned acc_w;
  int unsigned nbr_count;
  out_word_t totals_q[$];

  function automatic longint sext24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic add_report(in_word_t w);
    longint rx, ry, d, fx, fy, wt, e, k, mag;
    longint unsigned sq, e2, term, wa, wd, age, s;
    if (w.contact_expired) return;
    if (nbr_count >= MAX_NBR) return;
    rx = sext24(w.neighbour_x) - sext24(w.own_x);
    ry = sext24(w.neighbour_y) - sext24(w.own_y);
    sq = longint'(rx * rx) + longint'(ry * ry);
    d = longint'(root64(sq));
    if (d > longint'(regs.range_limit)) return;
    if (d == 0) begin
      fx = 0;
      fy = 0;
    end else if (d < (64'sd300 <<< POS_FRAC)) begin
      mag = 64'sd1000 <<< POS_FRAC;
      fx = -(mag * rx) / d;
      fy = -(mag * ry) / d;
    end else begin
      e = d - longint'(regs.zero_cross_distance);
      e2 = e * e;
      if (e2 == 0) term = TERM_CAP;
      else begin
        term = TERM_NUM / e2;
        if (term > TERM_CAP) term = TERM_CAP;
      end
      k = 64'sd65536 - longint'(term);
      fx = (k * rx) / 64'sd65536;
      fy = (k * ry) / 64'sd65536;
    end
    age = 64'(w.ping_age);
    if (regs.use_age_weight) begin
      if (regs.age_timeout == 0 || age >= regs.age_timeout) wa = 0;
      else wa = ((regs.age_timeout - age) << 16) / regs.age_timeout;
    end else begin
      wa = ONE_Q16;
    end
    if (regs.use_distance_weight) begin
      if (regs.range_limit == 0) wd = 0;
      else wd = (longint'(regs.range_limit) - d) * 65536 / regs.range_limit;
    end else begin
      wd = ONE_Q16;
    end
    wt = longint'((wa * wd) >> 16);
    fx = (fx * wt) / 64'sd65536;
    fy = (fy * wt) / 64'sd65536;
    acc_x = sat48(acc_x, fx);
    acc_y = sat48(acc_y, fy);
    s = longint'(acc_w) + (regs.weighted_average ? wt : 65536);
    acc_w = (s > 64'hFFFFFF) ? 32'hFFFFFF : 32'(s);
    nbr_count++;
  endtask

  task automatic finish_round();
    out_word_t r;
    longint fx, fy;
    r = '0;
    fx = acc_x;
    fy = acc_y;
    if (regs.average_enable) begin
      if (acc_w == 0) begin
        r.divide_fault = 1'b1;
        fx = 0;
        fy = 0;
      end else begin
        fx = (fx * 64'sd65536) / longint'(acc_w);
        fy = (fy * 64'sd65536) / longint'(acc_w);
      end
    end
    r.force_x = sat32(fx);
    r.force_y = sat32(fy);
    r.target_count = nbr_count[7:0];
    r.weight_total = acc_w[23:0];
    r.force_valid = nbr_count != 0;
    totals_q.push_back(r);
    acc_x = 0;
    acc_y = 0;
    acc_w = 0;
    nbr_count = 0;
  endtask

  assign pending_count = totals_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      regs <= '{24'd166400, 24'd2560, 24'd0, 1'b1, 1'b1, 1'b0, 1'b0};
      acc_x = 0;
      acc_y = 0;
      acc_w = 0;
      nbr_count = 0;
      fail_count <= 0;
      totals_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (totals_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = totals_q.pop_front();
          if (exp_w.force_x !== out_data.force_x || exp_w.force_y !== out_data.force_y
              || exp_w.target_count !== out_data.target_count
              || exp_w.weight_total !== out_data.weight_total
              || exp_w.force_valid !== out_data.force_valid
              || exp_w.divide_fault !== out_data.divide_fault) begin
            $display("%0t: mismatch expected fx=%0d fy=%0d n=%0d w=%0d v=%b f=%b",
                     $time, $signed(exp_w.force_x), $signed(exp_w.force_y),
                     exp_w.target_count, exp_w.weight_total, exp_w.force_valid,
                     exp_w.divide_fault);
            $display("%0t:          actual   fx=%0d fy=%0d n=%0d w=%0d v=%b f=%b",
                     $time, $signed(out_data.force_x), $signed(out_data.force_y),
                     out_data.target_count, out_data.weight_total, out_data.force_valid,
                     out_data.divide_fault);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command) finish_round();
        else add_report(in_data);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE:   regs.range_limit <= cfg_wdata;
          CFG_TIMEOUT: regs.age_timeout <= cfg_wdata;
          CFG_ZCROSS:  regs.zero_cross_distance <= cfg_wdata;
          CFG_AGE_EN:  regs.use_age_weight <= cfg_wdata[0];
          CFG_DIST_EN: regs.use_distance_weight <= cfg_wdata[0];
          CFG_AVG_EN:  regs.average_enable <= cfg_wdata[0];
          CFG_WAVG:    regs.weighted_average <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- verif/neighbour_force_accumulator_test.sv -----
// Stimulus and verdict for the neighbour force accumulator.
// Depends on nfa_pkg, the block and nfa_checker.
`timescale 1ns / 1ps
module neighbour_force_accumulator_test;
  import nfa_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd4000000;
  localparam int IN_W = $bits(in_word_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_RANGE;
  logic [23:0] cfg_wdata = '0;
  int          fail_count, pending_count;
  longint      cycle_count = 0;
  logic [23:0] cur_range = 24'd166400;

  always #5 clk = ~clk;

  neighbour_force_accumulator dut (.*);

  nfa_checker checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls at random, in bursts
  always @(posedge clk) begin
    if ($urandom_range(0, 9) < 3) out_stall <= $urandom_range(0, 1);
  end

  // valid stays high across back-to-back words; settle drops it
  task automatic send_word(in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_RANGE) cur_range = val;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic in_word_t make_report(int offset_max);
    in_word_t w;
    logic signed [23:0] ox, oy;
    w.command = 1'b0;
    w.own_x = 24'($urandom);
    w.own_y = 24'($urandom);
    ox = $signed(w.own_x);
    oy = $signed(w.own_y);
    if ($urandom_range(0, 9) < 2) begin
      w.neighbour_x = 24'($urandom);
      w.neighbour_y = 24'($urandom);
    end else begin
      w.neighbour_x = ox + 24'($signed($urandom_range(0, 2 * offset_max)) - offset_max);
      w.neighbour_y = oy + 24'($signed($urandom_range(0, 2 * offset_max)) - offset_max);
    end
    w.contact_expired = ($urandom_range(0, 9) == 0);
    w.ping_age = ($urandom_range(0, 4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    return w;
  endfunction

  function automatic in_word_t finish_word();
    in_word_t w;
    w = in_word_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    w.command = 1'b1;
    return w;
  endfunction

  initial begin
    in_word_t w;
    int span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero distance, near, far, extremes, expired, empty finish
    w = '0;
    send_word(w);
    w.neighbour_x = 24'd2560;
    send_word(w);
    w.neighbour_x = 24'd100000;
    w.ping_age = 24'd100;
    send_word(w);
    w.neighbour_x = 24'h7FFFFF;
    w.own_x = 24'h800000;
    send_word(w);
    w = '0;
    w.neighbour_y = 24'h800000;
    w.own_y = 24'h7FFFFF;
    w.ping_age = 24'hFFFFFF;
    send_word(w);
    w.contact_expired = 1'b1;
    send_word(w);
    send_word(finish_word());
    send_word(finish_word());
    settle();

    // divide fault, then zero-cross singularity with averaging
    write_reg(CFG_AVG_EN, 24'd1);
    write_reg(CFG_WAVG, 24'd1);
    w = '0;
    w.neighbour_x = 24'd2560;
    w.ping_age = 24'd5000;
    send_word(w);
    send_word(finish_word());
    settle();
    write_reg(CFG_RANGE, 24'hFFFFFF);
    write_reg(CFG_ZCROSS, 24'd100000);
    write_reg(CFG_AGE_EN, 24'd0);
    write_reg(CFG_DIST_EN, 24'd0);
    w = '0;
    w.neighbour_x = 24'd100000;
    send_word(w);
    w.neighbour_x = 24'd100001;
    w.neighbour_y = 24'hFFFFF0;
    send_word(w);
    send_word(finish_word());
    settle();
    // zero timeout and zero range
    write_reg(CFG_TIMEOUT, 24'd0);
    write_reg(CFG_AGE_EN, 24'd1);
    write_reg(CFG_DIST_EN, 24'd1);
    write_reg(CFG_RANGE, 24'd0);
    w = '0;
    send_word(w);
    w.neighbour_x = 24'd1;
    send_word(w);
    send_word(finish_word());
    settle();

    // random phases with varied settings; one phase sends more reports than the neighbour limit
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_RANGE, (ph == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 400000)));
      write_reg(CFG_TIMEOUT, (ph == 2) ? 24'hFFFFFF : 24'($urandom_range(1, 4000)));
      write_reg(CFG_ZCROSS, (ph == 3) ? 24'hFFFFFF : 24'($urandom_range(0, 120000)));
      write_reg(CFG_AGE_EN, 24'($urandom_range(0, 1)));
      write_reg(CFG_DIST_EN, 24'($urandom_range(0, 1)));
      write_reg(CFG_AVG_EN, 24'($urandom_range(0, 1)));
      write_reg(CFG_WAVG, 24'($urandom_range(0, 1)));
      span = (cur_range > 24'd200000) ? 200000 : int'(cur_range) + 2;
      if (ph == 4) begin
        repeat (260) send_word(make_report(span));
        send_word(finish_word());
      end else begin
        repeat (75) begin
          send_word(make_report(span));
          if ($urandom_range(0, 5) == 0) send_word(finish_word());
        end
        send_word(finish_word());
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
